FILE: hw/rtl/q2e_pkg.sv
// Shared types, widths and constants for the quaternion to Euler angle pipeline.
// No dependencies; used by q2e_atan2 and quaternion_to_euler_angles.
`default_nettype none
package q2e_pkg;

  localparam int QW      = 16;   // quaternion component width, Q2.14
  localparam int AW      = 16;   // angle width, Q3.13
  localparam int WFRAC   = 30;   // fraction bits of the internal terms
  localparam int QFRAC   = QW - 2;
  localparam int AFRAC   = AW - 3;
  localparam int MUL_SH  = WFRAC - 2 * QFRAC;
  localparam int TW      = 37;   // width of the t terms
  localparam int SW      = 62;   // width of the square root datapath
  localparam int CW      = 40;   // width of the CORDIC x and y registers
  localparam int ZW      = 35;   // width of the CORDIC angle accumulator
  localparam int STEPS   = 31;   // CORDIC iterations
  localparam int SQ_STEPS = 31;  // square root digits
  localparam int RND_SH  = WFRAC - AFRAC;

  // products, terms, square root input, square root digits
  localparam int FRONT_LAT = 3 + SQ_STEPS;
  // sign fold, iterations, clamp and round
  localparam int ATAN_LAT  = STEPS + 2;
  localparam int LAT       = FRONT_LAT + ATAN_LAT;

  localparam logic signed [TW-1:0] ONE_W = TW'(64'sd1 <<< WFRAC);
  localparam logic signed [ZW-1:0] PI_W  = ZW'(64'sd3373259426);

  typedef struct packed {
    logic signed [TW-1:0] t0;
    logic signed [TW-1:0] t1;
    logic signed [TW-1:0] t2;
    logic signed [TW-1:0] t3;
    logic signed [TW-1:0] t4;
  } terms_t;

  // atan(2^-i) with WFRAC fraction bits, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_coef(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = ZW'(64'sd843314857);
      1:  r = ZW'(64'sd497837829);
      2:  r = ZW'(64'sd263043837);
      3:  r = ZW'(64'sd133525159);
      4:  r = ZW'(64'sd67021687);
      5:  r = ZW'(64'sd33543516);
      6:  r = ZW'(64'sd16775851);
      7:  r = ZW'(64'sd8388437);
      8:  r = ZW'(64'sd4194283);
      9:  r = ZW'(64'sd2097149);
      default: r = ZW'(64'sd1 <<< (WFRAC - i));
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/q2e_atan2.sv
// Pipelined vectoring CORDIC atan2: sign fold, one stage per iteration,
// then clamp to +-pi and round to the angle format. Uses q2e_pkg.
`default_nettype none
module q2e_atan2 (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [q2e_pkg::TW-1:0]    y_in,
  input  wire logic signed [q2e_pkg::TW-1:0]    x_in,
  output logic signed [q2e_pkg::AW-1:0]         ang_out
);

  logic signed [q2e_pkg::CW-1:0] x_r [0:q2e_pkg::STEPS];
  logic signed [q2e_pkg::CW-1:0] y_r [0:q2e_pkg::STEPS];
  logic signed [q2e_pkg::ZW-1:0] z_r [0:q2e_pkg::STEPS];
  logic signed [q2e_pkg::CW-1:0] xe, ye;
  logic signed [q2e_pkg::ZW-1:0] zc, zr;
  logic signed [q2e_pkg::AW-1:0] ang_r;

  assign xe = q2e_pkg::CW'(x_in);
  assign ye = q2e_pkg::CW'(y_in);

  // fold the left half plane onto the right one, start at +-pi
  always_ff @(posedge clk) begin
    if (en) begin
      if (xe < 0) begin
        x_r[0] <= -xe;
        y_r[0] <= -ye;
        z_r[0] <= (ye >= 0) ? q2e_pkg::PI_W : -q2e_pkg::PI_W;
      end else begin
        x_r[0] <= xe;
        y_r[0] <= ye;
        z_r[0] <= '0;
      end
    end
  end

  // one rotation per stage; hold when y is already zero
  for (genvar i = 0; i < q2e_pkg::STEPS; i++) begin : g_step
    logic signed [q2e_pkg::CW-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + q2e_pkg::atan_coef(i);
        end else if (y_r[i] < 0) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - q2e_pkg::atan_coef(i);
        end else begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          z_r[i+1] <= z_r[i];
        end
      end
    end
  end

  // clamp to +-pi, round half up
  always_comb begin
    zc = z_r[q2e_pkg::STEPS];
    if (zc > q2e_pkg::PI_W) begin
      zc = q2e_pkg::PI_W;
    end
    if (zc < -q2e_pkg::PI_W) begin
      zc = -q2e_pkg::PI_W;
    end
    zr = (zc + (q2e_pkg::ZW'(1) <<< (q2e_pkg::RND_SH - 1))) >>> q2e_pkg::RND_SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= zr[q2e_pkg::AW-1:0];
    end
  end

  assign ang_out = ang_r;

endmodule
`default_nettype wire

FILE: hw/rtl/quaternion_to_euler_angles.sv
// Quaternion (Q2.14) to roll, pitch and yaw (Q3.13) streaming pipeline.
// Throughput: one item per cycle; the whole pipeline holds while the
// output item waits, and the 31-digit square root plus 31-step CORDIC
// set the depth. Reset (rst_n low, synchronous) empties all valid bits.
// Depends on q2e_pkg and q2e_atan2.
`default_nettype none
module quaternion_to_euler_angles (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // roll_angle, pitch_angle(15), yaw_angle, 0
);

  localparam int QW = q2e_pkg::QW;
  localparam int TW = q2e_pkg::TW;
  localparam int SW = q2e_pkg::SW;

  logic                     en;
  logic [q2e_pkg::LAT-1:0]  vld_r;
  logic signed [QW-1:0]     qx, qy, qz, qw;

  logic signed [2*QW-1:0] p_xx_r, p_yy_r, p_zz_r, p_xy_r, p_wz_r;
  logic signed [2*QW-1:0] p_wy_r, p_xz_r, p_yz_r, p_wx_r;
  q2e_pkg::terms_t        trm_nxt, trm_r;
  logic [30:0]            sq;
  logic [SW-1:0]          v_nxt;
  logic [SW-1:0]          v_r   [0:q2e_pkg::SQ_STEPS];
  logic [SW-1:0]          res_r [0:q2e_pkg::SQ_STEPS];
  q2e_pkg::terms_t        td_r  [0:q2e_pkg::SQ_STEPS];
  logic signed [TW-1:0]   cos_p;
  logic signed [q2e_pkg::AW-1:0] roll, pitch, yaw;

  function automatic logic signed [TW-1:0] mulw(input logic signed [2*QW-1:0] p);
    return TW'(p) <<< q2e_pkg::MUL_SH;
  endfunction

  assign en        = !vld_r[q2e_pkg::LAT-1] || out_tready;
  assign in_tready = en;
  assign qx = in_tdata[15:0];
  assign qy = in_tdata[31:16];
  assign qz = in_tdata[47:32];
  assign qw = in_tdata[63:48];

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[q2e_pkg::LAT-2:0], in_tvalid};
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      p_xx_r <= qx * qx;
      p_yy_r <= qy * qy;
      p_zz_r <= qz * qz;
      p_xy_r <= qx * qy;
      p_wz_r <= qw * qz;
      p_wy_r <= qw * qy;
      p_xz_r <= qx * qz;
      p_yz_r <= qy * qz;
      p_wx_r <= qw * qx;
    end
  end

  // stage 2: terms, clamp the pitch argument
  always_comb begin
    trm_nxt.t0 = q2e_pkg::ONE_W - ((mulw(p_yy_r) + mulw(p_zz_r)) <<< 1);
    trm_nxt.t1 = (mulw(p_xy_r) + mulw(p_wz_r)) <<< 1;
    trm_nxt.t2 = (mulw(p_wy_r) - mulw(p_xz_r)) <<< 1;
    trm_nxt.t3 = (mulw(p_yz_r) + mulw(p_wx_r)) <<< 1;
    trm_nxt.t4 = q2e_pkg::ONE_W - ((mulw(p_xx_r) + mulw(p_yy_r)) <<< 1);
    if (trm_nxt.t2 > q2e_pkg::ONE_W) begin
      trm_nxt.t2 = q2e_pkg::ONE_W;
    end
    if (trm_nxt.t2 < -q2e_pkg::ONE_W) begin
      trm_nxt.t2 = -q2e_pkg::ONE_W;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trm_r <= trm_nxt;
    end
  end

  // stage 3: radicand 1 - t2^2
  always_comb begin
    sq    = trm_r.t2[TW-1] ? 31'(-trm_r.t2) : trm_r.t2[30:0];
    v_nxt = (SW'(1) << (2 * q2e_pkg::WFRAC)) - (SW'(sq) * SW'(sq));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]   <= v_nxt;
      res_r[0] <= '0;
      td_r[0]  <= trm_r;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 1; k <= q2e_pkg::SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SW-1:0] BITC = SW'(1) << (2 * q2e_pkg::WFRAC - 2 * (k - 1));
    logic [SW-1:0] trial;
    assign trial = res_r[k-1] + BITC;
    always_ff @(posedge clk) begin
      if (en) begin
        td_r[k] <= td_r[k-1];
        if (v_r[k-1] >= trial) begin
          v_r[k]   <= v_r[k-1] - trial;
          res_r[k] <= (res_r[k-1] >> 1) + BITC;
        end else begin
          v_r[k]   <= v_r[k-1];
          res_r[k] <= res_r[k-1] >> 1;
        end
      end
    end
  end

  assign cos_p = TW'(res_r[q2e_pkg::SQ_STEPS][30:0]);

  q2e_atan2 u_roll (
    .clk     (clk),
    .en      (en),
    .y_in    (td_r[q2e_pkg::SQ_STEPS].t3),
    .x_in    (td_r[q2e_pkg::SQ_STEPS].t4),
    .ang_out (roll)
  );

  q2e_atan2 u_pitch (
    .clk     (clk),
    .en      (en),
    .y_in    (td_r[q2e_pkg::SQ_STEPS].t2),
    .x_in    (cos_p),
    .ang_out (pitch)
  );

  q2e_atan2 u_yaw (
    .clk     (clk),
    .en      (en),
    .y_in    (td_r[q2e_pkg::SQ_STEPS].t1),
    .x_in    (td_r[q2e_pkg::SQ_STEPS].t0),
    .ang_out (yaw)
  );

  assign out_tvalid = vld_r[q2e_pkg::LAT-1];
  assign out_tdata  = {1'b0, yaw, pitch[q2e_pkg::AW-2:0], roll};

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // pitch stays within +-pi/2
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(pitch) <= 16'sd12868 && $signed(pitch) >= -16'sd12868))
    else $error("pitch out of range");

  // roll and yaw stay within +-pi
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (roll <= 16'sd25736 && roll >= -16'sd25736 &&
                    yaw <= 16'sd25736 && yaw >= -16'sd25736))
    else $error("roll or yaw out of range");

  // a stalled output holds the pipeline
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while output stalled");

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for quaternion_to_euler_angles: drives Q2.14 quaternions on the input
// stream and checks roll, pitch and yaw against a bit-exact predictor in the bench.
// Depends on q2e_pkg and the quaternion_to_euler_angles RTL.
`default_nettype none
module tb;

  localparam int QFR      = 14;
  localparam int AFR      = 13;
  localparam longint ONE  = 64'sd1 <<< 30;
  localparam longint PI_Z = 64'sd3373259426;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;   // roll_angle, pitch_angle(15), yaw_angle, 0

  angles_t angle_queue[$];
  int      n_errors = 0;
  bit      stall_free = 1'b0;
  longint  atan_rom[31];

  quaternion_to_euler_angles u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    atan_rom = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                 128, 64, 32, 16, 8, 4, 2, 1};
  end

  // Floor product scaled to 30 fraction bits (28 here, so shift up).
  function automatic longint prod30(longint a, longint b);
    return (a * b) <<< (30 - 2 * QFR);
  endfunction

  function automatic longint root60(longint v);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC atan2 at 30 fraction bits, result rounded to Q3.13.
  function automatic longint arc_tan2(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Z : -PI_Z;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 31; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + atan_rom[i];
      end else if (y < 0) begin
        x = x - ys; y = y + xs; z = z - atan_rom[i];
      end
    end
    if (z > PI_Z) z = PI_Z;
    if (z < -PI_Z) z = -PI_Z;
    return (z + (64'sd1 <<< (29 - AFR))) >>> (30 - AFR);
  endfunction

  function automatic angles_t euler_of(logic [63:0] q);
    longint qx, qy, qz, qw, yy, t0, t1, t2, t3, t4, c;
    angles_t a;
    qx = longint'($signed(q[15:0]));
    qy = longint'($signed(q[31:16]));
    qz = longint'($signed(q[47:32]));
    qw = longint'($signed(q[63:48]));
    yy = prod30(qy, qy);
    t0 = ONE - 2 * (yy + prod30(qz, qz));
    t1 = 2 * (prod30(qx, qy) + prod30(qw, qz));
    t2 = 2 * (prod30(qw, qy) - prod30(qx, qz));
    t3 = 2 * (prod30(qy, qz) + prod30(qw, qx));
    t4 = ONE - 2 * (prod30(qx, qx) + yy);
    if (t2 > ONE) t2 = ONE;
    if (t2 < -ONE) t2 = -ONE;
    c = root60((64'sd1 <<< 60) - t2 * t2);
    a.roll  = 16'(arc_tan2(t3, t4));
    a.pitch = 15'(arc_tan2(t2, c));
    a.yaw   = 16'(arc_tan2(t1, t0));
    return a;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, int got, int exp);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, exp);
    n_errors++;
  endtask

  // Send one item, hold valid until accepted; drop valid only over a gap.
  task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           logic [15:0] w, bit idle_ok = 1'b1);
    int g;
    g = idle_ok ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w, z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    angle_queue.push_back(euler_of({w, z, y, x}));
  endtask

  // Back-pressure on the result side.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      g = stall_free ? 0 : gap_len();
      if (g == 0) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    angles_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = angles_t'(out_tdata[46:0]);
      if (angle_queue.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        exp = angle_queue.pop_front();
        if (got.roll !== exp.roll) report_mismatch("roll", got.roll, exp.roll);
        if (got.pitch !== exp.pitch) report_mismatch("pitch", got.pitch, exp.pitch);
        if (got.yaw !== exp.yaw) report_mismatch("yaw", got.yaw, exp.yaw);
        if (out_tdata[47] !== 1'b0) report_mismatch("pad bit", out_tdata[47], 0);
      end
    end
  end

  // Field extremes, identity, axis turns, zero and gimbal-lock cases.
  task automatic test_directed();
    logic [15:0] one, h;
    one = 16'sd16384;
    h = 16'sd11585;
    send_quat('0, '0, '0, one);
    send_quat('0, '0, '0, '0);
    send_quat(one, '0, '0, '0);
    send_quat('0, one, '0, '0);
    send_quat('0, '0, one, '0);
    send_quat(h, '0, '0, h);
    send_quat('0, h, '0, h);
    send_quat('0, -h, '0, h);
    send_quat('0, '0, h, h);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_quat(16'h8000, '0, '0, 16'h7fff);
    send_quat('0, 16'h7fff, '0, 16'h7fff);
    send_quat('0, 16'h8000, '0, 16'h7fff);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_quat(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
  endtask

  // Mostly near-unit quaternions with random direction, some raw noise.
  task automatic test_random(int n);
    int v[4];
    longint s2;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        s2 = 0;
        foreach (v[j]) begin
          v[j] = $signed($urandom_range(0, 32767)) - 16384;
          s2 += longint'(v[j]) * v[j];
        end
        if (s2 == 0) s2 = 1;
        foreach (v[j]) v[j] = int'((longint'(v[j]) * 16384) / longint'($sqrt(real'(s2))));
        send_quat(16'(v[0]), 16'(v[1]), 16'(v[2]), 16'(v[3]));
      end
    end
  endtask

  // Back-to-back stream with the sink always ready.
  task automatic test_full_rate(int n);
    stall_free = 1'b1;
    for (int k = 0; k < n; k++) begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    end
    stall_free = 1'b0;
  endtask

  initial begin
    int guard;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1300);
    test_full_rate(200);
    test_random(130);
    in_tvalid <= 1'b0;
    guard = 0;
    while (angle_queue.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (n_errors == 0 && angle_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
